[rtl/core/d2p_pkg.sv]
// Package for the disparity-to-point reprojection block: widths, word types,
// register indexes and reset values. No dependencies.
`default_nettype none

package d2p_pkg;

  localparam int D2P_COORD_BITS = 12;   // default coordinate width used from col/row
  localparam int RAW_W          = 16;   // raw disparity width, also divisor width
  localparam int POS_W          = 12;   // col/row field width
  localparam int COLOR_W        = 8;
  localparam int WORD_W         = 32;   // Q16.16 coordinate width
  localparam int LIMIT_W        = 31;
  localparam int CENTER_W       = 16;   // Q12.4 optic center
  localparam int CFG_IDX_W      = 3;
  localparam int LANES          = 3;

  // divider lanes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE   = 3'd0,
    REG_FOCAL_BASE = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_MIN_RAW    = 3'd4,
    REG_X_LIMIT    = 3'd5,
    REG_Z_LIMIT    = 3'd6
  } d2p_reg_t;

  localparam logic [RAW_W-1:0]   MIN_RAW_RESET = 16'd64;
  localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 31'd1638400;   // 25.0
  localparam logic [LIMIT_W-1:0] Z_LIMIT_RESET = 31'd5242880;   // 80.0

  typedef struct packed {
    logic [RAW_W-1:0]   raw_disparity;
    logic [POS_W-1:0]   pixel_col;
    logic [POS_W-1:0]   pixel_row;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } d2p_pixel_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x_pos;
    logic signed [WORD_W-1:0] y_pos;
    logic signed [WORD_W-1:0] z_pos;
    logic [COLOR_W-1:0]       red_out;
    logic [COLOR_W-1:0]       green_out;
    logic [COLOR_W-1:0]       blue_out;
  } d2p_point_t;

  // carried alongside the divider lanes
  typedef struct packed {
    logic               x_neg;   // sign of x result
    logic               y_neg;   // sign of y result (already negated)
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } d2p_side_t;

endpackage

`default_nettype wire

[rtl/core/d2p_divider.sv]
// Pipelined restoring divider, three numerator lanes sharing one divisor,
// two quotient bits per stage. Depends on d2p_pkg.
`default_nettype none

module d2p_divider import d2p_pkg::*; #(
  parameter int DIV_W = 50
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [RAW_W-1:0]                in_den,
  input  wire logic [LANES-1:0][DIV_W-1:0]     in_num,
  input  wire d2p_side_t                       in_side,
  output logic                                 out_valid,
  output logic [LANES-1:0][DIV_W-1:0]          out_quo,
  output d2p_side_t                            out_side
);

  localparam int STAGES = DIV_W / 2;

  logic [STAGES-1:0]                          valid;
  logic [STAGES-1:0][RAW_W-1:0]               den;
  logic [STAGES-1:0][LANES-1:0][RAW_W-1:0]    rem;
  logic [STAGES-1:0][LANES-1:0][DIV_W-1:0]    nq;   // numerator shifting out, quotient in
  d2p_side_t                                  side [STAGES];

  // one restoring step: returns {remainder, shifted numerator/quotient}
  function automatic logic [RAW_W+DIV_W-1:0] div_step(
    input logic [RAW_W-1:0] r,
    input logic [DIV_W-1:0] q,
    input logic [RAW_W-1:0] d
  );
    logic [RAW_W:0] t;
    logic [RAW_W:0] diff;
    logic           ge;
    t    = {r, q[DIV_W-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    return {(ge ? diff[RAW_W-1:0] : t[RAW_W-1:0]), q[DIV_W-2:0], ge};
  endfunction

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                          v_in;
    logic [RAW_W-1:0]              d_in;
    logic [LANES-1:0][RAW_W-1:0]   r_in;
    logic [LANES-1:0][DIV_W-1:0]   q_in;
    d2p_side_t                     s_in;
    logic [LANES-1:0][RAW_W-1:0]   r_out;
    logic [LANES-1:0][DIV_W-1:0]   q_out;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign d_in = in_den;
      assign r_in = '0;
      assign q_in = in_num;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = valid[s-1];
      assign d_in = den[s-1];
      assign r_in = rem[s-1];
      assign q_in = nq[s-1];
      assign s_in = side[s-1];
    end

    always_comb begin
      logic [RAW_W+DIV_W-1:0] step1;
      logic [RAW_W+DIV_W-1:0] step2;
      for (int l = 0; l < LANES; l++) begin
        step1    = div_step(r_in[l], q_in[l], d_in);
        step2    = div_step(step1[RAW_W+DIV_W-1:DIV_W], step1[DIV_W-1:0], d_in);
        r_out[l] = step2[RAW_W+DIV_W-1:DIV_W];
        q_out[l] = step2[DIV_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en) begin
        valid[s] <= v_in;
      end
      if (en) begin
        den[s]  <= d_in;
        rem[s]  <= r_out;
        nq[s]   <= q_out;
        side[s] <= s_in;
      end
    end
  end

  assign out_valid = valid[STAGES-1];
  assign out_quo   = nq[STAGES-1];
  assign out_side  = side[STAGES-1];

endmodule

`default_nettype wire

[rtl/core/disparity_to_point_reprojection_unit.sv]
// Top level of the disparity-to-point reprojection block: config registers,
// offset/multiply front end, divider pipeline, limit check and output register.
// Depends on d2p_pkg and d2p_divider.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------------
//   pixel   | in        | pixel_valid/pixel_stall| d2p_pixel_t (disparity, col, row, rgb)
//   point   | out       | point_valid/point_stall| d2p_point_t (x, y, z, rgb)
//   cfg     | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One pixel per clock unless a held point word stalls the pipeline. Stages in order:
// offset stage, multiply stage, DIV_W/2 divider stages at two bits each, output.
// Reset is synchronous; it clears the valid bits and loads the register defaults.
// A held point word stalls the whole pipeline; pixel_stall follows at once.
// Pixels that fail the disparity or limit checks leave as bubbles.
`default_nettype none

module disparity_to_point_reprojection_unit import d2p_pkg::*; #(
  parameter int COORD_BITS = D2P_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire d2p_pixel_t            pixel,
  output logic                       point_valid,
  input  wire logic                  point_stall,
  output d2p_point_t                 point,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data
);

  localparam int P16_W = COORD_BITS + 4;
  localparam int MAG_W = (P16_W > CENTER_W) ? P16_W : CENTER_W;
  localparam int NUM_W = MAG_W + WORD_W + 1;          // 2*B*mag
  localparam int DIV_W = NUM_W + (NUM_W % 2);

  localparam logic [DIV_W-1:0] POS_MAX = DIV_W'(32'h7FFF_FFFF);
  localparam logic [DIV_W-1:0] NEG_MAX = DIV_W'(32'h8000_0000);

  // ---------------- config registers ----------------
  logic [WORD_W-1:0]   baseline;
  logic [WORD_W-1:0]   focal_base;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [RAW_W-1:0]    min_raw;
  logic [LIMIT_W-1:0]  x_limit;
  logic [LIMIT_W-1:0]  z_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline   <= '0;
      focal_base <= '0;
      center_x   <= '0;
      center_y   <= '0;
      min_raw    <= MIN_RAW_RESET;
      x_limit    <= X_LIMIT_RESET;
      z_limit    <= Z_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASELINE:   baseline   <= cfg_data;
        REG_FOCAL_BASE: focal_base <= cfg_data;
        REG_CENTER_X:   center_x   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:   center_y   <= cfg_data[CENTER_W-1:0];
        REG_MIN_RAW:    min_raw    <= cfg_data[RAW_W-1:0];
        REG_X_LIMIT:    x_limit    <= cfg_data[LIMIT_W-1:0];
        REG_Z_LIMIT:    z_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  assign en          = !(point_valid && point_stall);
  assign pixel_stall = !en;

  // ---------------- stage a: offsets from the optic center ----------------
  logic [COORD_BITS-1:0] col_c, row_c;
  logic [MAG_W-1:0]      col_p, row_p, cx_p, cy_p;
  logic                  x_off_neg, y_off_neg;
  logic [MAG_W-1:0]      x_mag_next, y_mag_next;

  assign col_c     = COORD_BITS'({{COORD_BITS{1'b0}}, pixel.pixel_col});
  assign row_c     = COORD_BITS'({{COORD_BITS{1'b0}}, pixel.pixel_row});
  assign col_p     = MAG_W'({col_c, 4'b0000});
  assign row_p     = MAG_W'({row_c, 4'b0000});
  assign cx_p      = MAG_W'(center_x);
  assign cy_p      = MAG_W'(center_y);
  assign x_off_neg = col_p < cx_p;
  assign y_off_neg = row_p < cy_p;
  assign x_mag_next = x_off_neg ? (cx_p - col_p) : (col_p - cx_p);
  assign y_mag_next = y_off_neg ? (cy_p - row_p) : (row_p - cy_p);

  logic             a_valid;
  logic [RAW_W-1:0] a_raw;
  logic [MAG_W-1:0] a_x_mag, a_y_mag;
  d2p_side_t        a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      // small disparities drop out here
      a_valid <= pixel_valid && (pixel.raw_disparity > min_raw);
    end
    if (en) begin
      a_raw        <= pixel.raw_disparity;
      a_x_mag      <= x_mag_next;
      a_y_mag      <= y_mag_next;
      a_side.x_neg <= x_off_neg;
      a_side.y_neg <= !y_off_neg;   // y axis points up
      a_side.red   <= pixel.red_in;
      a_side.green <= pixel.green_in;
      a_side.blue  <= pixel.blue_in;
    end
  end

  // ---------------- stage b: numerators ----------------
  logic [NUM_W-1:0] prod_x, prod_y;
  assign prod_x = {baseline, 1'b0} * a_x_mag;
  assign prod_y = {baseline, 1'b0} * a_y_mag;

  logic                          b_valid;
  logic [RAW_W-1:0]              b_raw;
  logic [LANES-1:0][DIV_W-1:0]   b_num;
  d2p_side_t                     b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_raw         <= a_raw;
      b_num[LANE_X] <= DIV_W'(prod_x);
      b_num[LANE_Y] <= DIV_W'(prod_y);
      b_num[LANE_Z] <= DIV_W'({focal_base, 5'b00000});   // 32*F
      b_side        <= a_side;
    end
  end

  // ---------------- divider ----------------
  logic                          div_valid;
  logic [LANES-1:0][DIV_W-1:0]   div_quo;
  d2p_side_t                     div_side;

  d2p_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_den    (b_raw),
    .in_num    (b_num),
    .in_side   (b_side),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------- output stage: limits, signs, saturation ----------------
  logic [DIV_W-1:0]  q_x, q_y, q_z;
  logic              keep;
  logic [WORD_W-1:0] x_word, y_word, z_word;
  d2p_point_t        point_next;

  assign q_x  = div_quo[LANE_X];
  assign q_y  = div_quo[LANE_Y];
  assign q_z  = div_quo[LANE_Z];
  assign keep = div_valid && (q_z < DIV_W'(z_limit)) && (q_x < DIV_W'(x_limit));

  assign x_word = div_side.x_neg ? (WORD_W'(0) - q_x[WORD_W-1:0]) : q_x[WORD_W-1:0];
  assign z_word = WORD_W'(0) - q_z[WORD_W-1:0];

  always_comb begin
    if (!div_side.y_neg) begin
      y_word = (q_y > POS_MAX) ? POS_MAX[WORD_W-1:0] : q_y[WORD_W-1:0];
    end else begin
      y_word = (q_y > NEG_MAX) ? NEG_MAX[WORD_W-1:0] : (WORD_W'(0) - q_y[WORD_W-1:0]);
    end
  end

  always_comb begin
    point_next.x_pos     = x_word;
    point_next.y_pos     = y_word;
    point_next.z_pos     = z_word;
    point_next.red_out   = div_side.red;
    point_next.green_out = div_side.green;
    point_next.blue_out  = div_side.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (en) begin
      point_valid <= keep;
    end
    if (en) begin
      point <= point_next;
    end
  end

endmodule

`default_nettype wire

[sim/d2p_point_checker.sv]
// Checker for the disparity-to-point block: watches the pixel, point and config
// channels, predicts each point word and compares it with what the block emits.
// Depends on d2p_pkg.
module d2p_point_checker import d2p_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  input  logic                 pixel_stall,
  input  d2p_pixel_t           pixel,
  input  logic                 point_valid,
  input  logic                 point_stall,
  input  d2p_point_t           point,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WORD_W-1:0]   baseline_q;
  logic [WORD_W-1:0]   focal_q;
  logic [CENTER_W-1:0] center_x_q;
  logic [CENTER_W-1:0] center_y_q;
  logic [RAW_W-1:0]    min_raw_q;
  logic [LIMIT_W-1:0]  x_limit_q;
  logic [LIMIT_W-1:0]  z_limit_q;

  d2p_point_t expected_points[$];
  int         point_count = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // |2*B*(16*pos - center)| / raw, truncated; neg gives the sign of the offset
  function automatic logic [63:0] offset_quotient(input logic [POS_W-1:0] pos,
                                                  input logic [CENTER_W-1:0] center,
                                                  input logic [RAW_W-1:0] raw,
                                                  output bit neg);
    logic [63:0] pos16;
    logic [63:0] mag;
    pos16 = 64'(pos) << 4;
    if (pos16 >= 64'(center)) begin
      mag = pos16 - 64'(center);
      neg = 1'b0;
    end else begin
      mag = 64'(center) - pos16;
      neg = 1'b1;
    end
    return (64'd2 * 64'(baseline_q) * mag) / 64'(raw);
  endfunction

  // returns 1 when the pixel yields a point
  function automatic bit reproject(input d2p_pixel_t px, output d2p_point_t pt);
    logic [63:0] xq;
    logic [63:0] yq;
    logic [63:0] zq;
    bit          x_neg;
    bit          y_neg;
    pt = '0;
    if (px.raw_disparity <= min_raw_q) return 1'b0;
    zq = (64'(focal_q) * 64'd32) / 64'(px.raw_disparity);
    xq = offset_quotient(px.pixel_col, center_x_q, px.raw_disparity, x_neg);
    if (!(zq < 64'(z_limit_q) && xq < 64'(x_limit_q))) return 1'b0;
    yq = offset_quotient(px.pixel_row, center_y_q, px.raw_disparity, y_neg);
    y_neg = !y_neg;  // image rows grow downward
    if (!y_neg)
      pt.y_pos = (yq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : yq[31:0];
    else
      pt.y_pos = (yq > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - yq[31:0];
    pt.x_pos     = x_neg ? 32'd0 - xq[31:0] : xq[31:0];
    pt.z_pos     = 32'd0 - zq[31:0];
    pt.red_out   = px.red_in;
    pt.green_out = px.green_in;
    pt.blue_out  = px.blue_in;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("point %0d %s: expected %h, got %h", point_count, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    d2p_point_t want;
    if (rst) begin
      baseline_q = '0;
      focal_q    = '0;
      center_x_q = '0;
      center_y_q = '0;
      min_raw_q  = MIN_RAW_RESET;
      x_limit_q  = X_LIMIT_RESET;
      z_limit_q  = Z_LIMIT_RESET;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASELINE:   baseline_q = cfg_data;
          REG_FOCAL_BASE: focal_q    = cfg_data;
          REG_CENTER_X:   center_x_q = cfg_data[CENTER_W-1:0];
          REG_CENTER_Y:   center_y_q = cfg_data[CENTER_W-1:0];
          REG_MIN_RAW:    min_raw_q  = cfg_data[RAW_W-1:0];
          REG_X_LIMIT:    x_limit_q  = cfg_data[LIMIT_W-1:0];
          REG_Z_LIMIT:    z_limit_q  = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall && reproject(pixel, want))
        expected_points.insert(expected_points.size(), want);
      if (point_valid && !point_stall) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("point %0d: unexpected word %h", point_count, point);
        end else begin
          want = expected_points.pop_front();
          check_field("x_pos", want.x_pos, point.x_pos);
          check_field("y_pos", want.y_pos, point.y_pos);
          check_field("z_pos", want.z_pos, point.z_pos);
          check_field("red_out", 32'(want.red_out), 32'(point.red_out));
          check_field("green_out", 32'(want.green_out), 32'(point.green_out));
          check_field("blue_out", 32'(want.blue_out), 32'(point.blue_out));
        end
        point_count++;
      end
    end
    pending <= expected_points.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for disparity_to_point_reprojection_unit: clock, reset, config
// phases, pixel stimulus and point-side stalls. Checking is in d2p_point_checker.
// Depends on d2p_pkg, the block and the checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d2p_pkg::*;

  localparam int RESET_CYCLES    = 10;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int IDLE_LIMIT      = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  d2p_pixel_t           pixel = '0;
  logic                 point_valid;
  logic                 point_stall = 1'b0;
  d2p_point_t           point;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  int                   fail_count;
  int                   pending;

  logic hold_off_req = 1'b0;
  logic hold_off_served = 1'b0;
  bit   sender_quiet = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;

  // what stimulus shaping knows of the current setting
  int cur_min = 64;
  int cur_cx = 0;
  int cur_cy = 0;

  disparity_to_point_reprojection_unit dut (.*);
  d2p_point_checker point_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(input bit quiet);
    int sel;
    if (quiet) return 0;
    sel = $urandom_range(99);
    if (sel < 60) return 0;
    if (sel < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int near_coord(input int center16);
    return clamp((center16 >>> 4) + int'($urandom_range(0, 128)) - 64, 0, 4095);
  endfunction

  function automatic d2p_pixel_t random_pixel();
    d2p_pixel_t p;
    int         sel;
    int         raw;
    sel = $urandom_range(99);
    if (sel < 70 && cur_min < 65535)
      raw = $urandom_range(cur_min + 1, clamp(cur_min + 3000, 0, 65535));
    else if (sel < 80 || cur_min >= 65535)
      raw = $urandom_range(0, 65535);
    else if (sel < 90)
      raw = clamp(cur_min + int'($urandom_range(0, 4)) - 2, 0, 65535);
    else
      case ($urandom_range(3))
        0: raw = 0;
        1: raw = 1;
        2: raw = 65534;
        default: raw = 65535;
      endcase
    p.raw_disparity = 16'(raw);
    p.pixel_col = ($urandom_range(9) < 6) ? 12'(near_coord(cur_cx)) : 12'($urandom);
    p.pixel_row = ($urandom_range(9) < 6) ? 12'(near_coord(cur_cy)) : 12'($urandom);
    p.red_in    = 8'($urandom);
    p.green_in  = 8'($urandom);
    p.blue_in   = 8'($urandom);
    return p;
  endfunction

  task automatic send_pixel(input d2p_pixel_t p);
    int gap;
    if (items_sent % 60 == 0) sender_quiet = ($urandom_range(3) == 0);
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    items_sent++;
  endtask

  task automatic offer_pixel(input int raw, input int col, input int row,
                             input int red, input int green, input int blue);
    send_pixel('{16'(raw), 12'(col), 12'(row), 8'(red), 8'(green), 8'(blue)});
  endtask

  task automatic run_random(input int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  // pipeline drained: nothing expected, and bubbles have flushed out
  task automatic finish_phase();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input d2p_reg_t idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [31:0] base, input logic [31:0] focal,
                           input int cx, input int cy, input int min_raw,
                           input logic [31:0] x_lim, input logic [31:0] z_lim);
    write_reg(REG_BASELINE, base);
    write_reg(REG_FOCAL_BASE, focal);
    write_reg(REG_CENTER_X, 32'(cx));
    write_reg(REG_CENTER_Y, 32'(cy));
    write_reg(REG_MIN_RAW, 32'(min_raw));
    write_reg(REG_X_LIMIT, x_lim);
    write_reg(REG_Z_LIMIT, z_lim);
    cfg_valid <= 1'b0;
    cur_min = min_raw;
    cur_cx  = cx;
    cur_cy  = cy;
  endtask

  // point side: random stall bursts, quiet stretches, one long hold-off on request
  initial begin
    int n;
    int window;
    bit quiet;
    window = 0;
    quiet = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_served) begin
        point_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_served = 1'b1;
      end else begin
        if (window <= 0) begin
          quiet = ($urandom_range(3) == 0);
          window = 100;
        end
        n = pick_gap(quiet);
        if (n > 0) begin
          point_stall <= 1'b1;
          repeat (n) @(posedge clk);
          window -= n;
        end
        point_stall <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
        window -= n;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((pixel_valid && !pixel_stall) || (point_valid && !point_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("** disparity_to_point_reprojection_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset setting: zero baseline and focal product give the origin
    offer_pixel(0, 0, 0, 8'h00, 8'h00, 8'h00);
    offer_pixel(64, 4095, 4095, 8'hFF, 8'hFF, 8'hFF);
    offer_pixel(65, 4095, 0, 8'hAA, 8'h55, 8'hFF);
    offer_pixel(65535, 2048, 2048, 8'h01, 8'h80, 8'hFE);
    finish_phase();

    // plausible camera; x limit edge sits between raw 99 and 98 at column 0
    load_regs(32'd7864, 32'd5505024, 16 * 640, 16 * 360, 64, 32'(X_LIMIT_RESET),
              32'd2000000);
    offer_pixel(65, 640, 360, 8'h10, 8'h20, 8'h30);
    offer_pixel(64, 640, 360, 8'h11, 8'h21, 8'h31);
    offer_pixel(100, 640, 360, 8'h12, 8'h22, 8'h32);
    offer_pixel(100, 0, 0, 8'h13, 8'h23, 8'h33);
    offer_pixel(99, 0, 0, 8'h14, 8'h24, 8'h34);
    offer_pixel(98, 0, 0, 8'h15, 8'h25, 8'h35);
    offer_pixel(200, 4095, 4095, 8'h16, 8'h26, 8'h36);
    offer_pixel(2000, 4095, 4095, 8'h17, 8'h27, 8'h37);
    offer_pixel(65535, 1000, 700, 8'hFF, 8'h00, 8'hFF);
    run_random(40);
    hold_off_req <= 1'b1;  // sender keeps going while the point side holds off
    run_random(210);
    finish_phase();

    // full baseline, zero depth: y saturates negative
    load_regs(32'hFFFF_FFFF, 32'd0, 16 * 2048, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_pixel(0, 2048, 0, 8'h01, 8'h02, 8'h03);
    offer_pixel(1, 2048, 4095, 8'h04, 8'h05, 8'h06);
    offer_pixel(65535, 2048, 4095, 8'h07, 8'h08, 8'h09);
    offer_pixel(3, 2047, 0, 8'h0A, 8'h0B, 8'h0C);
    offer_pixel(65535, 2047, 2048, 8'h0D, 8'h0E, 8'h0F);
    offer_pixel(65535, 2048, 0, 8'h80, 8'h40, 8'h20);
    run_random(80);
    finish_phase();

    // zero limits: nothing passes
    load_regs(32'd7864, 32'd5505024, 16 * 640, 16 * 360, 64, 32'd0, 32'd0);
    run_random(40);
    finish_phase();

    // largest minimum: no disparity exceeds it
    load_regs(32'd7864, 32'd5505024, 16 * 640, 16 * 360, 65535, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    offer_pixel(65535, 640, 360, 8'hC0, 8'hC1, 8'hC2);
    run_random(30);
    finish_phase();

    // full focal product: depth limit edge between raw 64 and 65; y saturates positive
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16 * 100, 16'hFFFF, 0, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    offer_pixel(65535, 100, 0, 8'h31, 8'h32, 8'h33);
    offer_pixel(64, 100, 0, 8'h34, 8'h35, 8'h36);
    offer_pixel(65, 100, 0, 8'h37, 8'h38, 8'h39);
    run_random(100);
    finish_phase();

    repeat (3) begin
      load_regs($urandom_range(1000, 200000), $urandom_range(100000, 20000000),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 400), $urandom_range(32'h10000, 32'h100_0000),
                $urandom_range(32'h10000, 32'h100_0000));
      run_random(110);
      finish_phase();
    end

    if (fail_count == 0)
      $display("** disparity_to_point_reprojection_unit: PASSED **");
    else
      $display("** disparity_to_point_reprojection_unit: FAILED **");
    $finish;
  end

endmodule

[files.f]
rtl/core/d2p_pkg.sv
rtl/core/d2p_divider.sv
rtl/core/disparity_to_point_reprojection_unit.sv
sim/d2p_point_checker.sv
sim/tb.sv
